FILE: rtl/core/lfca_pkg.sv
// Package for the link frame check and acknowledgement block.
// Holds frame layout constants, CRC constants and the transaction payload types.
// No dependencies.
package lfca_pkg;

    localparam int PAYLOAD_MAX = 512;
    localparam int HDR_LEN     = 32;
    localparam int FRAME_LEN   = HDR_LEN + PAYLOAD_MAX;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);
    localparam int SIZE_W      = 10;

    localparam logic [31:0] LINK_MAGIC        = 32'h314b4c4d;
    localparam logic [7:0]  LINK_VERSION      = 8'd1;
    localparam int          FLAG_PAYLOAD_BIT  = 0;
    localparam int          FLAG_ACK_BIT      = 1;
    localparam logic [31:0] CRC_POLY          = 32'hedb88320;
    localparam logic [31:0] CRC_INIT          = 32'hffffffff;
    localparam logic [31:0] OWN_SESSION_RESET = 32'd1;

    // header byte offsets
    localparam int OFS_MAGIC    = 0;
    localparam int OFS_VERSION  = 4;
    localparam int OFS_FLAGS    = 5;
    localparam int OFS_RSVD8    = 7;
    localparam int OFS_SESSION  = 8;
    localparam int OFS_SEQ      = 12;
    localparam int OFS_ACK_SEQ  = 14;
    localparam int OFS_SIZE     = 16;
    localparam int OFS_RSVD16   = 18;
    localparam int OFS_PAY_CRC  = 20;
    localparam int OFS_HDR_CRC  = 24;
    localparam int OFS_PEER     = 28;

    typedef enum logic {
        KIND_RX_BYTE = 1'b0,
        KIND_STAGE   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        rx_byte;
        logic [SIZE_W-1:0] stage_size;
    } in_item_t;

    typedef struct packed {
        logic              frame_end;
        logic              frame_good;
        logic              deliver;
        logic [SIZE_W-1:0] deliver_size;
        logic              sent_acked;
        logic              need_exchange;
        logic              send_payload;
        logic [15:0]       send_sequence;
        logic              send_ack;
        logic [15:0]       ack_number;
        logic [31:0]       peer_id;
    } out_item_t;

endpackage

FILE: rtl/core/link_frame_check_and_ack.sv
// Receive-side frame checker with stop-and-wait acknowledgement tracking.
// A transaction is held in the input register; its result goes to the result register.
// Throughput: one transaction per cycle unless results stall; set by the byte-wide CRC
//   update and end-of-frame judgment, one pass between input and result register.
// Reset (aresetn low, synchronous): pipeline empties, CRCs go to all ones, session
//   and sequence state clears, own_session returns to 1. Header bytes are not reset.
module link_frame_check_and_ack (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lfca_pkg::in_item_t   s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output lfca_pkg::out_item_t  m_data,
    // own_session write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    localparam logic [lfca_pkg::POS_W-1:0] POS_LAST = lfca_pkg::POS_W'(lfca_pkg::FRAME_LEN - 1);
    localparam logic [lfca_pkg::POS_W-1:0] POS_HDR  = lfca_pkg::POS_W'(lfca_pkg::HDR_LEN);

    // Reflected CRC-32 over one byte, bit at a time.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? lfca_pkg::CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    lfca_pkg::in_item_t    in_data_reg;
    logic                  out_valid_reg;
    lfca_pkg::out_item_t   out_data_reg;
    logic                  advance;

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    logic [31:0]                 own_session_reg;
    logic [lfca_pkg::POS_W-1:0]  byte_pos_reg,        byte_pos_next;
    logic [31:0]                 header_crc_reg,      header_crc_next;
    logic [31:0]                 payload_crc_reg,     payload_crc_next;
    logic [7:0]                  header_capture_reg [lfca_pkg::HDR_LEN];
    logic [31:0]                 remote_id_reg,       remote_id_next;
    logic                        remote_seen_reg,     remote_seen_next;
    logic [15:0]                 tx_seq_reg,          tx_seq_next;
    logic [15:0]                 rx_expected_reg,     rx_expected_next;
    logic [15:0]                 rx_last_reg,         rx_last_next;
    logic                        ack_valid_reg,       ack_valid_next;
    logic                        ack_owed_reg,        ack_owed_next;
    logic                        out_pending_reg,     out_pending_next;

    lfca_pkg::out_item_t         result;

    // Advance the held transaction when the result register is free or being drained;
    // the input register takes a new transaction in the same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Header field views (little endian)
    // ------------------------------------------------------------------
    logic [31:0] hdr_magic, hdr_session, hdr_pay_crc, hdr_hdr_crc, hdr_peer;
    logic [15:0] hdr_seq, hdr_ack_seq, hdr_size, hdr_rsvd16;
    logic [7:0]  hdr_version, hdr_flags, hdr_rsvd8;

    function automatic logic [15:0] pick16(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo};
    endfunction

    always_comb begin
        hdr_magic   = {pick16(header_capture_reg[lfca_pkg::OFS_MAGIC + 2],
                              header_capture_reg[lfca_pkg::OFS_MAGIC + 3]),
                       pick16(header_capture_reg[lfca_pkg::OFS_MAGIC],
                              header_capture_reg[lfca_pkg::OFS_MAGIC + 1])};
        hdr_session = {pick16(header_capture_reg[lfca_pkg::OFS_SESSION + 2],
                              header_capture_reg[lfca_pkg::OFS_SESSION + 3]),
                       pick16(header_capture_reg[lfca_pkg::OFS_SESSION],
                              header_capture_reg[lfca_pkg::OFS_SESSION + 1])};
        hdr_pay_crc = {pick16(header_capture_reg[lfca_pkg::OFS_PAY_CRC + 2],
                              header_capture_reg[lfca_pkg::OFS_PAY_CRC + 3]),
                       pick16(header_capture_reg[lfca_pkg::OFS_PAY_CRC],
                              header_capture_reg[lfca_pkg::OFS_PAY_CRC + 1])};
        hdr_hdr_crc = {pick16(header_capture_reg[lfca_pkg::OFS_HDR_CRC + 2],
                              header_capture_reg[lfca_pkg::OFS_HDR_CRC + 3]),
                       pick16(header_capture_reg[lfca_pkg::OFS_HDR_CRC],
                              header_capture_reg[lfca_pkg::OFS_HDR_CRC + 1])};
        hdr_peer    = {pick16(header_capture_reg[lfca_pkg::OFS_PEER + 2],
                              header_capture_reg[lfca_pkg::OFS_PEER + 3]),
                       pick16(header_capture_reg[lfca_pkg::OFS_PEER],
                              header_capture_reg[lfca_pkg::OFS_PEER + 1])};
        hdr_seq     = pick16(header_capture_reg[lfca_pkg::OFS_SEQ],
                             header_capture_reg[lfca_pkg::OFS_SEQ + 1]);
        hdr_ack_seq = pick16(header_capture_reg[lfca_pkg::OFS_ACK_SEQ],
                             header_capture_reg[lfca_pkg::OFS_ACK_SEQ + 1]);
        hdr_size    = pick16(header_capture_reg[lfca_pkg::OFS_SIZE],
                             header_capture_reg[lfca_pkg::OFS_SIZE + 1]);
        hdr_rsvd16  = pick16(header_capture_reg[lfca_pkg::OFS_RSVD16],
                             header_capture_reg[lfca_pkg::OFS_RSVD16 + 1]);
        hdr_version = header_capture_reg[lfca_pkg::OFS_VERSION];
        hdr_flags   = header_capture_reg[lfca_pkg::OFS_FLAGS];
        hdr_rsvd8   = header_capture_reg[lfca_pkg::OFS_RSVD8];
    end

    // ------------------------------------------------------------------
    // Single pass: staging, byte intake, CRC update, end-of-frame judgment
    // ------------------------------------------------------------------
    logic                        in_header;
    logic                        in_payload;
    logic [lfca_pkg::POS_W-1:0]  pay_off;
    logic [lfca_pkg::SIZE_W-1:0] stage_sat;
    logic                        fend, good, dlv, acked, changed, peer_ok;
    logic                        flag_pay, flag_ack;
    logic [31:0]                 pay_crc_upd;
    logic [7:0]                  hdr_crc_byte;

    always_comb begin
        byte_pos_next    = byte_pos_reg;
        header_crc_next  = header_crc_reg;
        payload_crc_next = payload_crc_reg;
        remote_id_next   = remote_id_reg;
        remote_seen_next = remote_seen_reg;
        tx_seq_next      = tx_seq_reg;
        rx_expected_next = rx_expected_reg;
        rx_last_next     = rx_last_reg;
        ack_valid_next   = ack_valid_reg;
        ack_owed_next    = ack_owed_reg;
        out_pending_next = out_pending_reg;

        fend     = 1'b0;
        good     = 1'b0;
        dlv      = 1'b0;
        acked    = 1'b0;
        changed  = 1'b0;
        peer_ok  = 1'b0;
        flag_pay = hdr_flags[lfca_pkg::FLAG_PAYLOAD_BIT];
        flag_ack = hdr_flags[lfca_pkg::FLAG_ACK_BIT];

        in_header  = byte_pos_reg < POS_HDR;
        pay_off    = byte_pos_reg - POS_HDR;
        in_payload = !in_header && (16'(pay_off) < hdr_size);

        // the stored header CRC field is counted as zero
        hdr_crc_byte = (byte_pos_reg >= lfca_pkg::POS_W'(lfca_pkg::OFS_HDR_CRC) &&
                        byte_pos_reg <  lfca_pkg::POS_W'(lfca_pkg::OFS_HDR_CRC + 4))
                       ? 8'd0 : in_data_reg.rx_byte;
        pay_crc_upd  = in_payload ? crc_byte(payload_crc_reg, in_data_reg.rx_byte)
                                  : payload_crc_reg;

        stage_sat = (in_data_reg.stage_size > lfca_pkg::SIZE_W'(lfca_pkg::PAYLOAD_MAX))
                    ? lfca_pkg::SIZE_W'(lfca_pkg::PAYLOAD_MAX) : in_data_reg.stage_size;

        unique case (in_data_reg.kind)
            lfca_pkg::KIND_STAGE: begin
                // ignore staging while a payload is still pending
                if (!out_pending_reg) begin
                    out_pending_next = stage_sat != '0;
                end
            end
            lfca_pkg::KIND_RX_BYTE: begin
                if (in_header) begin
                    header_crc_next = crc_byte(header_crc_reg, hdr_crc_byte);
                end
                payload_crc_next = pay_crc_upd;

                if (byte_pos_reg == POS_LAST) begin
                    fend          = 1'b1;
                    ack_owed_next = 1'b0;   // cleared on every frame end; payload frames below may set it again

                    good = (hdr_magic == lfca_pkg::LINK_MAGIC) &&
                           (hdr_version == lfca_pkg::LINK_VERSION) &&
                           (hdr_rsvd8 == 8'd0) && (hdr_rsvd16 == 16'd0) &&
                           (hdr_size <= 16'(lfca_pkg::PAYLOAD_MAX)) &&
                           (~header_crc_reg == hdr_hdr_crc) &&
                           (flag_pay ? (hdr_size != 16'd0 && ~pay_crc_upd == hdr_pay_crc)
                                     : (hdr_size == 16'd0));

                    if (good) begin
                        changed = !remote_seen_reg || (hdr_session != remote_id_reg);
                        if (changed) begin
                            remote_id_next   = hdr_session;
                            remote_seen_next = 1'b1;
                            ack_valid_next   = 1'b0;
                            if (flag_pay) begin
                                rx_expected_next = hdr_seq;
                            end
                        end
                        peer_ok = (hdr_peer == 32'd0) || (hdr_peer == own_session_reg);
                        if (peer_ok) begin
                            if (!changed && out_pending_reg && flag_ack &&
                                hdr_ack_seq == tx_seq_reg) begin
                                out_pending_next = 1'b0;
                                tx_seq_next      = tx_seq_reg + 16'd1;
                                acked            = 1'b1;
                            end
                            if (flag_pay) begin
                                priority if (ack_valid_next && hdr_seq == rx_last_reg) begin
                                    // duplicate: acknowledge again
                                    ack_owed_next = 1'b1;
                                end else if (hdr_seq != rx_expected_next) begin
                                    ack_owed_next = ack_valid_next;
                                end else begin
                                    dlv              = 1'b1;
                                    rx_last_next     = hdr_seq;
                                    rx_expected_next = hdr_seq + 16'd1;
                                    ack_valid_next   = 1'b1;
                                    ack_owed_next    = 1'b1;
                                end
                            end
                        end
                    end

                    byte_pos_next    = '0;
                    header_crc_next  = lfca_pkg::CRC_INIT;
                    payload_crc_next = lfca_pkg::CRC_INIT;
                end else begin
                    byte_pos_next = byte_pos_reg + 1'b1;
                end
            end
            default: ;
        endcase

        result.frame_end     = fend;
        result.frame_good    = good;
        result.deliver       = dlv;
        result.deliver_size  = dlv ? hdr_size[lfca_pkg::SIZE_W-1:0] : '0;
        result.sent_acked    = acked;
        result.need_exchange = ack_owed_next;
        result.send_payload  = out_pending_next;
        result.send_sequence = out_pending_next ? tx_seq_next : 16'd0;
        result.send_ack      = ack_valid_next;
        result.ack_number    = ack_valid_next ? rx_last_next : 16'd0;
        result.peer_id       = remote_seen_next ? remote_id_next : 32'd0;
    end

    // ------------------------------------------------------------------
    // Header byte capture (no reset: every byte is written before the frame end)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (advance && in_data_reg.kind == lfca_pkg::KIND_RX_BYTE && in_header) begin
            header_capture_reg[byte_pos_reg[lfca_pkg::HDR_IDX_W-1:0]] <= in_data_reg.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // Control and tracking state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            own_session_reg <= lfca_pkg::OWN_SESSION_RESET;
            byte_pos_reg    <= '0;
            header_crc_reg  <= lfca_pkg::CRC_INIT;
            payload_crc_reg <= lfca_pkg::CRC_INIT;
            remote_id_reg   <= 32'd0;
            remote_seen_reg <= 1'b0;
            tx_seq_reg      <= 16'd0;
            rx_expected_reg <= 16'd0;
            rx_last_reg     <= 16'd0;
            ack_valid_reg   <= 1'b0;
            ack_owed_reg    <= 1'b0;
            out_pending_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                own_session_reg <= cfg_data;
            end

            if (advance) begin
                byte_pos_reg    <= byte_pos_next;
                header_crc_reg  <= header_crc_next;
                payload_crc_reg <= payload_crc_next;
                remote_id_reg   <= remote_id_next;
                remote_seen_reg <= remote_seen_next;
                tx_seq_reg      <= tx_seq_next;
                rx_expected_reg <= rx_expected_next;
                rx_last_reg     <= rx_last_next;
                ack_valid_reg   <= ack_valid_next;
                ack_owed_reg    <= ack_owed_next;
                out_pending_reg <= out_pending_next;
            end
        end
    end

endmodule
